FILE: sv/dfq_pkg.sv
// Package for the dynamic flight qualifier: register map, reset values,
// detection thresholds and the structs passed between the qualifier modules.
// No dependencies.
package dfq_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_SPEED_THRESHOLD = 2'd0,
    REG_DWELL_COUNT     = 2'd1,
    REG_TRIM_SLEW_LIMIT = 2'd2
  } reg_idx_t;

  localparam logic [15:0] SPEED_THRESHOLD_RST = 16'd250;
  localparam logic [6:0]  DWELL_COUNT_RST     = 7'd100;
  localparam logic [9:0]  TRIM_SLEW_LIMIT_RST = 10'd400;

  localparam logic [9:0]         THROTTLE_MOVING_MILLI = 10'd800;
  localparam logic signed [15:0] PITCH_MOVING_CDEG     = -16'sd1500;
  localparam logic [15:0]        RANGE_MOVING_CM       = 16'd200;

  typedef struct packed {
    logic [15:0] speed_threshold_cms;
    logic [6:0]  dwell_count;
    logic [9:0]  trim_slew_limit;
  } cfg_t;

  typedef struct packed {
    logic               spool_unlimited;
    logic               mode_landing;
    logic               position_valid;
    logic [15:0]        speed_xy_cms;
    logic [9:0]         throttle_milli;
    logic signed [15:0] pitch_cdeg;
    logic               range_good;
    logic [15:0]        range_cm;
  } motion_t;

endpackage

FILE: sv/dfq_regs.sv
// Configuration register file behind the APB-style port.
// Depends on dfq_pkg.
module dfq_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfq_pkg::ADDR_W-1:0]    paddr,
  input  logic [dfq_pkg::DATA_W-1:0]    pwdata,
  output logic [dfq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output dfq_pkg::cfg_t                 cfg
);
  import dfq_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_threshold_cms <= SPEED_THRESHOLD_RST;
      cfg.dwell_count         <= DWELL_COUNT_RST;
      cfg.trim_slew_limit     <= TRIM_SLEW_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SPEED_THRESHOLD: cfg.speed_threshold_cms <= pwdata[15:0];
        REG_DWELL_COUNT:     cfg.dwell_count         <= pwdata[6:0];
        REG_TRIM_SLEW_LIMIT: cfg.trim_slew_limit     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SPEED_THRESHOLD: prdata = {16'd0, cfg.speed_threshold_cms};
      REG_DWELL_COUNT:     prdata = {25'd0, cfg.dwell_count};
      REG_TRIM_SLEW_LIMIT: prdata = {22'd0, cfg.trim_slew_limit};
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: sv/dfq_dwell.sv
// Movement detection plus dwell counter and dynamic-flight flag with hysteresis.
// Depends on dfq_pkg.
module dfq_dwell (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  dfq_pkg::cfg_t    cfg,
  input  dfq_pkg::motion_t mot,
  output logic             dyn_flag_next
);
  import dfq_pkg::*;

  logic       dyn_flag;
  logic [6:0] dwell_counter;
  logic [6:0] dwell_counter_next;
  logic       moving_primary;
  logic       moving;
  logic [6:0] cnt_inc;

  always_comb begin
    if (mot.position_valid) begin
      moving_primary = mot.speed_xy_cms >= cfg.speed_threshold_cms;
    end else begin
      moving_primary = (mot.throttle_milli > THROTTLE_MOVING_MILLI) ||
                       (mot.pitch_cdeg < PITCH_MOVING_CDEG);
    end
    moving = moving_primary || (mot.range_good && (mot.range_cm > RANGE_MOVING_CM));
  end

  assign cnt_inc = dwell_counter + 7'd1;

  always_comb begin
    dwell_counter_next = dwell_counter;
    dyn_flag_next      = dyn_flag;
    if (!mot.spool_unlimited || mot.mode_landing) begin
      dwell_counter_next = '0;
      dyn_flag_next      = 1'b0;
    end else if (moving) begin
      if (!dyn_flag) begin
        if (cnt_inc >= cfg.dwell_count) begin
          dyn_flag_next      = 1'b1;
          dwell_counter_next = cfg.dwell_count;
        end else begin
          dwell_counter_next = cnt_inc;
        end
      end
    end else if (dyn_flag) begin
      if (dwell_counter != 7'd0) begin
        dwell_counter_next = dwell_counter - 7'd1;
      end else begin
        dyn_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_counter <= '0;
      dyn_flag      <= 1'b0;
    end else if (adv) begin
      dwell_counter <= dwell_counter_next;
      dyn_flag      <= dyn_flag_next;
    end
  end

endmodule

FILE: sv/dfq_trim.sv
// Hover roll trim slew counter, clamped to 0..trim_slew_limit.
// Depends on dfq_pkg.
module dfq_trim (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  dfq_pkg::cfg_t cfg,
  input  logic          ramp_down,
  output logic [9:0]    trim_slew_next
);
  import dfq_pkg::*;

  logic [9:0]  trim_slew;
  logic [10:0] stepped;

  always_comb begin
    if (ramp_down) begin
      stepped = (trim_slew == 10'd0) ? 11'd0 : {1'b0, trim_slew} - 11'd1;
    end else begin
      stepped = {1'b0, trim_slew} + 11'd1;
    end
    // clamp to ceiling; a lowered limit pulls the count down at once
    if (stepped > {1'b0, cfg.trim_slew_limit}) begin
      trim_slew_next = cfg.trim_slew_limit;
    end else begin
      trim_slew_next = stepped[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_slew <= '0;
    end else if (adv) begin
      trim_slew <= trim_slew_next;
    end
  end

endmodule

FILE: sv/dynamic_flight_qualifier_unit.sv
// Dynamic flight qualifier: top level with input register, result register, config port.
// A transaction taken into the input register moves to the result register, with out_valid
// high, when adv is set; a stalled result register holds it in the input register. Throughput
// one transaction per cycle while out_stall is low; dwell and slew state update once per item.
// in_stall is high only while the input register holds an item the stalled result
// register cannot take. Synchronous active-high reset clears pipeline valids,
// dwell/flag/slew state and restores register defaults (threshold 250, dwell 100,
// slew limit 400).
// Depends on dfq_pkg, dfq_regs, dfq_dwell, dfq_trim.
module dynamic_flight_qualifier_unit (
  input  logic                       clk,
  input  logic                       rst,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfq_pkg::ADDR_W-1:0] paddr,
  input  logic [dfq_pkg::DATA_W-1:0] pwdata,
  output logic [dfq_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       spool_unlimited,
  input  logic                       mode_landing,
  input  logic                       position_valid,
  input  logic [15:0]                speed_xy_cms,
  input  logic [9:0]                 throttle_milli,
  input  logic signed [15:0]         pitch_cdeg,
  input  logic                       range_good,
  input  logic [15:0]                range_cm,
  input  logic                       manual_throttle_mode,
  input  logic                       landed,
  input  logic                       auto_ready,
  input  logic                       rotor_demand_zero,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       fwd_flight,
  output logic                       landing_swash,
  output logic [9:0]                 hover_trim_count
);
  import dfq_pkg::*;

  cfg_t cfg;

  // input register stage
  logic    s1_valid;
  motion_t s1_mot;
  logic    s1_manual;
  logic    s1_landed;
  logic    s1_auto_ready;
  logic    s1_demand_zero;

  logic       out_free;   // result register can take a new transaction
  logic       adv;        // stage 1 item moves to result register, state commits
  logic       in_take;
  logic       dyn_flag_next;
  logic [9:0] trim_slew_next;
  logic       swash_next;

  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && out_free;
  // input register holds while its item cannot move on
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mot.spool_unlimited <= spool_unlimited;
      s1_mot.mode_landing    <= mode_landing;
      s1_mot.position_valid  <= position_valid;
      s1_mot.speed_xy_cms    <= speed_xy_cms;
      s1_mot.throttle_milli  <= throttle_milli;
      s1_mot.pitch_cdeg      <= pitch_cdeg;
      s1_mot.range_good      <= range_good;
      s1_mot.range_cm        <= range_cm;
      s1_manual              <= manual_throttle_mode;
      s1_landed              <= landed;
      s1_auto_ready          <= auto_ready;
      s1_demand_zero         <= rotor_demand_zero;
    end
  end

  dfq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dfq_dwell u_dwell (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .cfg           (cfg),
    .mot           (s1_mot),
    .dyn_flag_next (dyn_flag_next)
  );

  dfq_trim u_trim (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .cfg            (cfg),
    .ramp_down      (s1_landed || s1_demand_zero),
    .trim_slew_next (trim_slew_next)
  );

  // landing swash uses the freshly updated flag; manual throttle never limits
  assign swash_next = !s1_manual &&
                      (s1_mot.mode_landing || s1_landed || !s1_auto_ready || !dyn_flag_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_flight       <= dyn_flag_next;
      landing_swash    <= swash_next;
      hover_trim_count <= trim_slew_next;
    end
  end

endmodule
